/* design/ipoc_pkg.sv */
// ipoc_pkg: shared constants and types for the interval peak overlap counter
// no dependencies; used by interval_peak_overlap_counter
package ipoc_pkg;

  localparam int MAX_BOOKINGS = 512;
  localparam int TABLE_DEPTH  = 2 * MAX_BOOKINGS;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = ADDR_W + 1;
  localparam int RUN_W        = CNT_W + 1;
  localparam int POS_W        = 30;
  localparam int KEY_W        = POS_W + 1;
  localparam int PEAK_W       = 10;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS_START,
    ST_INS_END,
    ST_SWEEP
  } ipoc_state_t;

endpackage

/* design/ipoc_ram.sv */
// ipoc_ram: generic single-write, single-read ram with registered read data
// no dependencies
module ipoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/interval_peak_overlap_counter.sv */
// Interval peak overlap counter. A request (start high while busy is low) carries one
// half-open booking [in_start_time, in_end_time). Its start and end markers are
// insertion-sorted into an event table held in one ram (one write and one registered
// read a cycle), end before start at equal positions, then the whole table is swept to
// find the peak running count. Each marker insertion moves up, one entry at a time, the
// stored markers that sort above it; the sweep reads the stored markers in turn, both
// through the single ram port pair. busy stays high throughout. The result shows on
// out_peak_overlap and out_table_full for exactly one cycle with out_valid high; the
// receiver cannot stall it. When the table already holds MAX_BOOKINGS bookings the
// booking is dropped and out_table_full is set. The table needs no clearing after reset.
// depends on ipoc_pkg and ipoc_ram
module interval_peak_overlap_counter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ipoc_pkg::POS_W-1:0]  in_start_time,
  input  logic [ipoc_pkg::POS_W-1:0]  in_end_time,
  output logic                        out_valid,
  output logic [ipoc_pkg::PEAK_W-1:0] out_peak_overlap,
  output logic                        out_table_full
);
  import ipoc_pkg::*;

  ipoc_state_t              state_r, state_nxt;
  cnt_t                     count_r, count_nxt;
  addr_t                    ptr_r, ptr_nxt;
  logic                     pend_r, pend_nxt;
  cnt_t                     k_r, k_nxt;
  logic                     vld_r, vld_nxt;
  logic signed [RUN_W-1:0]  run_r, run_nxt;
  cnt_t                     best_r, best_nxt;
  logic                     full_r, full_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [PEAK_W-1:0]        peak_r, peak_nxt;
  logic                     tfull_r, tfull_nxt;
  logic [POS_W-1:0]         s_r, e_r;

  logic                     accept;
  logic                     full_now;
  key_t                     key;
  logic                     ram_we, ram_re;
  addr_t                    ram_waddr, ram_raddr;
  key_t                     ram_wdata, ram_rdata;
  logic signed [RUN_W-1:0]  run_inc;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign full_now = ({1'b0, count_r} + (CNT_W + 1)'(2)) > (CNT_W + 1)'(TABLE_DEPTH);
  assign key      = (state_r == ST_INS_END) ? {e_r, 1'b0} : {s_r, 1'b1};
  assign run_inc  = run_r + RUN_W'(1);

  ipoc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    k_r     <= k_nxt;
    run_r   <= run_nxt;
    best_r  <= best_nxt;
    full_r  <= full_nxt;
    peak_r  <= peak_nxt;
    tfull_r <= tfull_nxt;
    if (accept) begin
      s_r <= in_start_time;
      e_r <= in_end_time;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    k_nxt         = k_r;
    vld_nxt       = 1'b0;
    run_nxt       = run_r;
    best_nxt      = best_r;
    full_nxt      = full_r;
    out_valid_nxt = 1'b0;
    peak_nxt      = peak_r;
    tfull_nxt     = tfull_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = key;
    ram_re        = 1'b0;
    ram_raddr     = ptr_r - ADDR_W'(1);

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          full_nxt = full_now;
          ptr_nxt  = count_r[ADDR_W-1:0];
          pend_nxt = 1'b0;
          k_nxt    = '0;
          run_nxt  = '0;
          best_nxt = '0;
          state_nxt = full_now ? ST_SWEEP : ST_INS_START;
        end
      end

      ST_INS_START, ST_INS_END: begin
        if (!pend_r) begin
          if (ptr_r == '0) begin
            ram_we = 1'b1;
          end else begin
            ram_re   = 1'b1;
            pend_nxt = 1'b1;
          end
        end else if (ram_rdata > key) begin
          // move the entry up one and look one further down
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          ptr_nxt   = ptr_r - ADDR_W'(1);
          if (ptr_r != ADDR_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r - ADDR_W'(2);
          end else begin
            pend_nxt = 1'b0;
          end
        end else begin
          ram_we = 1'b1;
        end

        // marker placed: the key went in this cycle
        if (ram_we && (ram_wdata == key) && !(pend_r && (ram_rdata > key))) begin
          count_nxt = count_r + CNT_W'(1);
          pend_nxt  = 1'b0;
          if (state_r == ST_INS_START) begin
            ptr_nxt   = count_nxt[ADDR_W-1:0];
            state_nxt = ST_INS_END;
          end else begin
            state_nxt = ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        if (k_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = k_r[ADDR_W-1:0];
          vld_nxt   = 1'b1;
          k_nxt     = k_r + CNT_W'(1);
        end
        if (vld_r) begin
          if (ram_rdata[0]) begin
            run_nxt = run_inc;
            if (run_inc > $signed({1'b0, best_r})) begin
              best_nxt = run_inc[CNT_W-1:0];
            end
          end else begin
            run_nxt = run_r - RUN_W'(1);
          end
        end
        if ((k_r == count_r) && !vld_r) begin
          out_valid_nxt = 1'b1;
          peak_nxt      = best_r[PEAK_W-1:0];
          tfull_nxt     = full_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_peak_overlap = peak_r;
  assign out_table_full   = tfull_r;

  // a result only follows a finished sweep
  a_result_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SWEEP))
    else $error("result without a sweep");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("event count beyond table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // a reported full table still has no room for two more markers
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> full_now)
    else $error("table full reported with room left");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("event count moved by more than one");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench for interval_peak_overlap_counter: bookings go in through the start/busy request
// port, each strobed result is checked against a sorted marker table kept here; uses ipoc_pkg
module testbench;
  import ipoc_pkg::*;

  localparam int TOTAL_BOOKINGS = 580;
  localparam int TAIL_CYCLES    = 3200;
  localparam int CYCLE_LIMIT    = 8000000;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
  } booking_t;

  typedef struct packed {
    logic [PEAK_W-1:0] peak;
    logic              full;
  } overlap_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [POS_W-1:0]    in_start_time = '0;
  logic [POS_W-1:0]    in_end_time = '0;
  logic                out_valid;
  logic [PEAK_W-1:0]   out_peak_overlap;
  logic                out_table_full;

  booking_t            booking_queue[$];
  overlap_result_t     peak_queue[$];
  key_t                marker_tab[TABLE_DEPTH];
  int                  marker_cnt = 0;
  int                  accepted_cnt = 0;
  int                  mismatches = 0;
  int                  cycle_cnt = 0;

  interval_peak_overlap_counter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_start_time    (in_start_time),
    .in_end_time      (in_end_time),
    .out_valid        (out_valid),
    .out_peak_overlap (out_peak_overlap),
    .out_table_full   (out_table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    mismatches++;
  endtask

  task automatic add_booking(input logic [POS_W-1:0] s_pos, input logic [POS_W-1:0] e_pos);
    booking_t b;
    b.start_pos = s_pos;
    b.end_pos   = e_pos;
    booking_queue.push_back(b);
  endtask

  // keeps the marker table in ascending key order, equal keys are identical
  function automatic void insert_marker(input key_t key);
    int i;
    i = marker_cnt;
    while (i > 0 && marker_tab[i-1] > key) begin
      marker_tab[i] = marker_tab[i-1];
      i--;
    end
    marker_tab[i] = key;
    marker_cnt++;
  endfunction

  function automatic overlap_result_t sweep_overlap(input logic [POS_W-1:0] s_pos,
                                                    input logic [POS_W-1:0] e_pos);
    overlap_result_t res;
    int run;
    int best;
    int i;
    res.full = (marker_cnt + 2 > TABLE_DEPTH);
    if (!res.full) begin
      insert_marker({s_pos, 1'b1});
      insert_marker({e_pos, 1'b0});
    end
    run  = 0;
    best = 0;
    for (i = 0; i < marker_cnt; i++) begin
      if (marker_tab[i][0]) begin
        run++;
        if (run > best) best = run;
      end else begin
        run--;
      end
    end
    res.peak = PEAK_W'(best);
    return res;
  endfunction

  // request driver: a new booking goes on the ports once the previous one is taken
  always @(posedge clk) begin
    booking_t nxt;
    int       idle_pct;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        peak_queue.push_back(sweep_overlap(in_start_time, in_end_time));
        accepted_cnt++;
      end
      if (accepted_cnt < TOTAL_BOOKINGS / 3) idle_pct = 23;
      else if (accepted_cnt < 2 * TOTAL_BOOKINGS / 3) idle_pct = 50;
      else idle_pct = 0;
      if (!start || !busy) begin
        if (booking_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = booking_queue.pop_front();
          start         <= 1'b1;
          in_start_time <= nxt.start_pos;
          in_end_time   <= nxt.end_pos;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    overlap_result_t exp_res;
    if (rst_n && out_valid) begin
      if (peak_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result peak %0d full %0b",
                                  out_peak_overlap, out_table_full));
      end else begin
        exp_res = peak_queue.pop_front();
        if (out_peak_overlap !== exp_res.peak)
          report_mismatch($sformatf("peak_overlap %0d, want %0d",
                                    out_peak_overlap, exp_res.peak));
        if (out_table_full !== exp_res.full)
          report_mismatch($sformatf("table_full %0b, want %0b",
                                    out_table_full, exp_res.full));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int unsigned s_val;
    int unsigned e_val;
    int unsigned len;
    int unsigned tmp;
    int          kind;
    int          n;

    // directed: extremes, empty and inverted bookings, touching ends, ties, nesting
    add_booking(0, 1);
    add_booking(0, 0);
    add_booking(POS_MAX, POS_MAX);
    add_booking(0, POS_MAX);
    add_booking(POS_MAX - POS_W'(1), POS_MAX);
    add_booking(POS_MAX, 0);
    add_booking(10, 20);
    add_booking(20, 30);
    add_booking(15, 25);
    add_booking(10, 20);
    add_booking(30'h2AAAAAAA, 30'h15555555);
    add_booking(30'h15555555, 30'h2AAAAAAA);
    add_booking(100, 200);
    add_booking(110, 190);
    add_booking(120, 180);
    add_booking(130, 170);
    add_booking(170, 170);
    add_booking(5, 5);
    add_booking(5, 5);
    add_booking(200, 100);
    add_booking(0, 1);
    add_booking(1, 2);

    n = TOTAL_BOOKINGS - booking_queue.size();
    repeat (n) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // dense cluster near zero: plenty of overlaps and equal positions
        s_val = $urandom_range(0, 511);
        len   = $urandom_range(1, 64);
        e_val = s_val + len;
      end else if (kind < 65) begin
        s_val = POS_MAX - $urandom_range(0, 600);
        len   = $urandom_range(1, 64);
        e_val = s_val + len;
        if (e_val > POS_MAX) e_val = POS_MAX;
      end else if (kind < 80) begin
        s_val = $urandom_range(0, POS_MAX);
        e_val = $urandom_range(0, POS_MAX);
        if (s_val > e_val) begin
          tmp   = s_val;
          s_val = e_val;
          e_val = tmp;
        end
      end else if (kind < 90) begin
        s_val = ($urandom_range(0, 1) != 0) ? $urandom_range(0, POS_MAX)
                                            : $urandom_range(0, 511);
        e_val = s_val;
      end else begin
        // inverted: end before start
        s_val = $urandom_range(1, POS_MAX);
        e_val = ($urandom_range(0, 1) != 0) ? $urandom_range(0, s_val - 1)
                                            : ((s_val > 32) ? s_val - $urandom_range(1, 32) : 0);
      end
      add_booking(s_val[POS_W-1:0], e_val[POS_W-1:0]);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (booking_queue.size() != 0 || start) @(posedge clk);
    while (peak_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
